// ===== hdl/nbcsf_pkg.sv =====
// ----------------------------------------------------------------------------
// nbcsf_pkg
// shared types and constants of the neighbor cone sample filter
// ----------------------------------------------------------------------------
package nbcsf_pkg;

    localparam int MAX_NEIGHBORS_DEF = 64;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;
    localparam logic [1:0] REG_THRESH   = 2'd3;

    localparam logic signed [17:0] THRESH_RESET = 18'sd65536;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } item_t;

    typedef struct packed {
        logic       selected;
        logic [1:0] status;
    } result_t;

endpackage

// ===== hdl/neighbor_cone_sample_filter.sv =====
// ----------------------------------------------------------------------------
// neighbor_cone_sample_filter
// keeps or rejects a sample point against a center and a neighbor store
// ----------------------------------------------------------------------------
// Usage: software writes the center and the cone cosine through wr_en,
// wr_index and wr_data while the block is idle. Each beat on the item channel
// (valid/ready) gives exactly one beat on the result channel. Clear and add
// beats go straight to the finish state. A test beat walks each stored
// neighbor in turn, with the exact cone compare where it is needed; a
// sample rejected early stops walking the store. All multiplications run
// through one shared 36x36 multiply-accumulate unit, and neighbors are read
// one per pass from a single-port memory, so these loops set the rate.
// One item is in work at a time; item_ready is high whenever the sequencer
// is idle, also while a result waits in the output register. A stalled
// receiver holds the result; the next result waits until it is taken.
// Reset clears the neighbor count, the center and sets the threshold to one.
// The neighbor memory is not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
module neighbor_cone_sample_filter #(
    parameter int MAX_NEIGHBORS = nbcsf_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [31:0]        wr_data,
    input  logic               item_valid,
    output logic               item_ready,
    input  nbcsf_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_ready,
    output nbcsf_pkg::result_t result
);

    localparam int CW    = $clog2(MAX_NEIGHBORS + 1);
    localparam int IW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int ACC_W = 200;

    typedef enum logic [3:0] {
        S_IDLE, S_U, S_MAC, S_DRAIN, S_CAP, S_RD, S_VW, S_DEC, S_FIN
    } state_t;

    typedef enum logic [2:0] {
        G_T2, G_NU, G_TNU, G_NW, G_NV, G_DOT, G_CMP
    } grp_t;

    state_t state_reg;
    grp_t   grp_reg;
    logic [3:0] stp_reg;

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic signed [17:0] thr_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] k_reg;

    logic [95:0] mem [MAX_NEIGHBORS];
    logic [95:0] rd_data_reg;

    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic signed [33:0] u_reg [3];
    logic signed [33:0] v_reg [3];
    logic signed [33:0] w_reg [3];
    logic [34:0]  t2_reg;
    logic [65:0]  nu_reg, nv_reg, nw_reg;
    logic [101:0] tnu_reg;
    logic signed [67:0] dot_reg;
    logic [65:0]  dm_reg;

    logic signed [35:0] mul_a, mul_b;
    logic [6:0] mul_sh;
    logic       mul_neg;
    logic       iss_v;

    logic signed [71:0] prod_reg;
    logic        p_v_reg, p_clr_reg, p_neg_reg;
    logic [6:0]  p_sh_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] addend;

    logic               res_sel_reg;
    logic [1:0]         res_st_reg;
    logic               result_valid_reg;
    nbcsf_pkg::result_t result_reg;

    logic [3:0]  glen;
    logic [17:0] tm;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    logic signed [33:0] nx, ny, nz;
    logic        hit_cmp;
    logic [CW-1:0] k_inc;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign tm = thr_reg[17] ? 18'(-thr_reg) : 18'(thr_reg);
    assign nx = 34'($signed(rd_data_reg[95:64]));
    assign ny = 34'($signed(rd_data_reg[63:32]));
    assign nz = 34'($signed(rd_data_reg[31:0]));
    assign hit_cmp = thr_reg[17] ? (acc_reg < 0) : (acc_reg > 0);
    assign k_inc = k_reg + CW'(1);

    assign mem_we = item_valid && item_ready && (item.op == nbcsf_pkg::OP_ADD)
        && !(item.pos_x == cx_reg && item.pos_y == cy_reg && item.pos_z == cz_reg)
        && (count_reg < CW'(MAX_NEIGHBORS));
    assign mem_waddr = count_reg[IW-1:0];

    always_comb
    begin
        unique case (grp_reg)
            G_T2:    glen = 4'd1;
            G_TNU:   glen = 4'd2;
            G_CMP:   glen = 4'd10;
            default: glen = 4'd3;
        endcase
    end

    // operand selection of the shared multiplier
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sh  = 7'd0;
        mul_neg = 1'b0;
        unique case (grp_reg)
            G_T2:
            begin
                mul_a = 36'({18'd0, tm});
                mul_b = 36'({18'd0, tm});
            end
            G_NU:
            begin
                mul_a = 36'(u_reg[stp_reg[1:0]]);
                mul_b = 36'(u_reg[stp_reg[1:0]]);
            end
            G_NW:
            begin
                mul_a = 36'(w_reg[stp_reg[1:0]]);
                mul_b = 36'(w_reg[stp_reg[1:0]]);
            end
            G_NV:
            begin
                mul_a = 36'(v_reg[stp_reg[1:0]]);
                mul_b = 36'(v_reg[stp_reg[1:0]]);
            end
            G_DOT:
            begin
                mul_a = 36'(u_reg[stp_reg[1:0]]);
                mul_b = 36'(v_reg[stp_reg[1:0]]);
            end
            G_TNU:
            begin
                mul_a = $signed({1'b0, t2_reg});
                if (stp_reg[0])
                begin
                    mul_b  = $signed({4'd0, nu_reg[65:34]});
                    mul_sh = 7'd34;
                end
                else
                begin
                    mul_b = $signed({2'd0, nu_reg[33:0]});
                end
            end
            G_CMP:
            begin
                mul_neg = (stp_reg >= 4'd4);
                unique case (stp_reg)
                    4'd0:
                    begin
                        mul_a = $signed({2'd0, dm_reg[33:0]});
                        mul_b = $signed({2'd0, dm_reg[33:0]});
                        mul_sh = 7'd32;
                    end
                    4'd1, 4'd2:
                    begin
                        mul_a = $signed({2'd0, dm_reg[33:0]});
                        mul_b = $signed({4'd0, dm_reg[65:34]});
                        mul_sh = 7'd66;
                    end
                    4'd3:
                    begin
                        mul_a = $signed({4'd0, dm_reg[65:34]});
                        mul_b = $signed({4'd0, dm_reg[65:34]});
                        mul_sh = 7'd100;
                    end
                    4'd4:
                    begin
                        mul_a = $signed({2'd0, tnu_reg[33:0]});
                        mul_b = $signed({2'd0, nv_reg[33:0]});
                        mul_sh = 7'd0;
                    end
                    4'd5:
                    begin
                        mul_a = $signed({2'd0, tnu_reg[33:0]});
                        mul_b = $signed({4'd0, nv_reg[65:34]});
                        mul_sh = 7'd34;
                    end
                    4'd6:
                    begin
                        mul_a = $signed({2'd0, tnu_reg[67:34]});
                        mul_b = $signed({2'd0, nv_reg[33:0]});
                        mul_sh = 7'd34;
                    end
                    4'd7:
                    begin
                        mul_a = $signed({2'd0, tnu_reg[67:34]});
                        mul_b = $signed({4'd0, nv_reg[65:34]});
                        mul_sh = 7'd68;
                    end
                    4'd8:
                    begin
                        mul_a = $signed({2'd0, tnu_reg[101:68]});
                        mul_b = $signed({2'd0, nv_reg[33:0]});
                        mul_sh = 7'd68;
                    end
                    4'd9:
                    begin
                        mul_a = $signed({2'd0, tnu_reg[101:68]});
                        mul_b = $signed({4'd0, nv_reg[65:34]});
                        mul_sh = 7'd102;
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign iss_v  = (state_reg == S_MAC);
    assign addend = p_neg_reg ? -(ACC_W'(prod_reg) <<< p_sh_reg)
                              : (ACC_W'(prod_reg) <<< p_sh_reg);

    // multiply stage and accumulator
    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        p_clr_reg <= (stp_reg == 4'd0);
        p_neg_reg <= mul_neg;
        p_sh_reg  <= mul_sh;
        if (p_v_reg)
        begin
            acc_reg <= (p_clr_reg ? ACC_W'(0) : acc_reg) + addend;
        end
    end

    // neighbor memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {item.pos_x, item.pos_y, item.pos_z};
        end
        if (state_reg == S_RD)
        begin
            rd_data_reg <= mem[k_reg[IW-1:0]];
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            sx_reg <= item.pos_x;
            sy_reg <= item.pos_y;
            sz_reg <= item.pos_z;
        end
        if (state_reg == S_U)
        begin
            u_reg[0] <= 34'(sx_reg) - 34'(cx_reg);
            u_reg[1] <= 34'(sy_reg) - 34'(cy_reg);
            u_reg[2] <= 34'(sz_reg) - 34'(cz_reg);
        end
        if (state_reg == S_VW)
        begin
            v_reg[0] <= nx - 34'(cx_reg);
            v_reg[1] <= ny - 34'(cy_reg);
            v_reg[2] <= nz - 34'(cz_reg);
            w_reg[0] <= 34'(sx_reg) - nx;
            w_reg[1] <= 34'(sy_reg) - ny;
            w_reg[2] <= 34'(sz_reg) - nz;
        end
        if (state_reg == S_CAP)
        begin
            unique case (grp_reg)
                G_T2:    t2_reg  <= acc_reg[34:0];
                G_NU:    nu_reg  <= acc_reg[65:0];
                G_TNU:   tnu_reg <= acc_reg[101:0];
                G_NW:    nw_reg  <= acc_reg[65:0];
                G_NV:    nv_reg  <= acc_reg[65:0];
                G_DOT:   dot_reg <= acc_reg[67:0];
                default: dot_reg <= dot_reg;
            endcase
        end
        if (state_reg == S_DEC)
        begin
            dm_reg <= dot_reg[67] ? 66'(-dot_reg) : dot_reg[65:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            grp_reg          <= G_T2;
            stp_reg          <= 4'd0;
            p_v_reg          <= 1'b0;
            cx_reg           <= '0;
            cy_reg           <= '0;
            cz_reg           <= '0;
            thr_reg          <= nbcsf_pkg::THRESH_RESET;
            count_reg        <= '0;
            k_reg            <= '0;
            res_sel_reg      <= 1'b0;
            res_st_reg       <= nbcsf_pkg::ST_OK;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            p_v_reg <= iss_v;

            if (wr_en)
            begin
                unique case (wr_index)
                    nbcsf_pkg::REG_CENTER_X: cx_reg  <= wr_data;
                    nbcsf_pkg::REG_CENTER_Y: cy_reg  <= wr_data;
                    nbcsf_pkg::REG_CENTER_Z: cz_reg  <= wr_data;
                    nbcsf_pkg::REG_THRESH:   thr_reg <= wr_data[17:0];
                    default:                 thr_reg <= thr_reg;
                endcase
            end

            // the finish state loads the next beat itself
            if (result_valid_reg && result_ready && (state_reg != S_FIN))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        res_sel_reg <= 1'b0;
                        res_st_reg  <= nbcsf_pkg::ST_OK;
                        state_reg   <= S_FIN;
                        unique case (item.op)
                            nbcsf_pkg::OP_CLEAR: count_reg <= '0;
                            nbcsf_pkg::OP_ADD:
                            begin
                                if (item.pos_x == cx_reg && item.pos_y == cy_reg
                                    && item.pos_z == cz_reg)
                                begin
                                    res_st_reg <= nbcsf_pkg::ST_SKIP;
                                end
                                else if (count_reg >= CW'(MAX_NEIGHBORS))
                                begin
                                    res_st_reg <= nbcsf_pkg::ST_FULL;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CW'(1);
                                end
                            end
                            nbcsf_pkg::OP_TEST: state_reg <= S_U;
                            default:            state_reg <= S_FIN;
                        endcase
                    end
                end
                S_U:
                begin
                    grp_reg   <= G_T2;
                    stp_reg   <= 4'd0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (stp_reg == glen - 4'd1)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        stp_reg <= stp_reg + 4'd1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_CAP;
                end
                S_CAP:
                begin
                    stp_reg <= 4'd0;
                    unique case (grp_reg)
                        G_T2:
                        begin
                            grp_reg   <= G_NU;
                            state_reg <= S_MAC;
                        end
                        G_NU:
                        begin
                            grp_reg   <= G_TNU;
                            state_reg <= S_MAC;
                        end
                        G_TNU:
                        begin
                            k_reg <= '0;
                            if (count_reg == '0)
                            begin
                                res_sel_reg <= 1'b1;
                                state_reg   <= S_FIN;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                            end
                        end
                        G_NW:
                        begin
                            grp_reg   <= G_NV;
                            state_reg <= S_MAC;
                        end
                        G_NV:
                        begin
                            grp_reg   <= G_DOT;
                            state_reg <= S_MAC;
                        end
                        G_DOT:
                        begin
                            state_reg <= S_DEC;
                        end
                        default:
                        begin
                            // exact cone compare done
                            if (hit_cmp)
                            begin
                                state_reg <= S_FIN;
                            end
                            else if (k_inc >= count_reg)
                            begin
                                res_sel_reg <= 1'b1;
                                state_reg   <= S_FIN;
                            end
                            else
                            begin
                                k_reg     <= k_inc;
                                state_reg <= S_RD;
                            end
                        end
                    endcase
                end
                S_RD:
                begin
                    state_reg <= S_VW;
                end
                S_VW:
                begin
                    grp_reg   <= G_NW;
                    stp_reg   <= 4'd0;
                    state_reg <= S_MAC;
                end
                S_DEC:
                begin
                    stp_reg <= 4'd0;
                    priority if (nu_reg > nw_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if ((nu_reg != '0) && (nv_reg != '0) && (
                        ((thr_reg == '0) && (dot_reg > 0)) ||
                        (thr_reg[17] && !dot_reg[67])))
                    begin
                        state_reg <= S_FIN;
                    end
                    else if ((nu_reg != '0) && (nv_reg != '0) && (thr_reg != '0)
                        && (thr_reg[17] || (dot_reg > 0)))
                    begin
                        grp_reg   <= G_CMP;
                        state_reg <= S_MAC;
                    end
                    else if (k_inc >= count_reg)
                    begin
                        res_sel_reg <= 1'b1;
                        state_reg   <= S_FIN;
                    end
                    else
                    begin
                        k_reg     <= k_inc;
                        state_reg <= S_RD;
                    end
                end
                S_FIN:
                begin
                    if (!result_valid_reg || result_ready)
                    begin
                        result_valid_reg    <= 1'b1;
                        result_reg.selected <= res_sel_reg;
                        result_reg.status   <= res_st_reg;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/nbcsf_check.sv =====
// ----------------------------------------------------------------------------
// nbcsf_check
// port-level checks of the neighbor cone sample filter
// ----------------------------------------------------------------------------
module nbcsf_check (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input nbcsf_pkg::result_t result
);

    // one item in work at a time
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken back to back");

    // a kept sample never carries a status
    a_sel_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.selected |-> result.status == nbcsf_pkg::ST_OK)
        else $error("selected with nonzero status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status != 2'd3)
        else $error("undefined status code");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

endmodule

bind neighbor_cone_sample_filter nbcsf_check u_nbcsf_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
